>>> hdl/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_DIV  = 2'd1;
  localparam logic [1:0] CMD_CONV = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [31:0] POS_SAT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_SAT = 32'h8000_0000;

  localparam logic [7:0] EXP_MAX    = 8'hff;
  localparam int         CONV_BIAS  = 150;
  localparam int         SHIFT_MAX  = 8;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]  result;
    logic [1:0]          status;
  } out_word_t;

endpackage

>>> hdl/qau_mul.sv
`timescale 1ns / 1ps

module qau_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [31:0]    in_a,
  input  logic signed [31:0]    in_b,
  output logic                  out_valid,
  output qau_pkg::out_word_t    out_word
);

  logic               v1_r, v2_r;
  logic signed [63:0] prod_r;
  qau_pkg::out_word_t word_r, word_nxt;
  logic [32-FRAC_BITS:0] top_bits;

  assign top_bits = prod_r[63:FRAC_BITS+31];

  always_comb begin
    word_nxt.result = prod_r[FRAC_BITS+31:FRAC_BITS];
    word_nxt.status = ((&top_bits) || !(|top_bits)) ? qau_pkg::ST_OK : qau_pkg::ST_OVF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    prod_r <= 64'(in_a) * 64'(in_b);
    word_r <= word_nxt;
  end

  assign out_valid = v2_r;
  assign out_word  = word_r;

endmodule

>>> hdl/qau_conv.sv
`timescale 1ns / 1ps

module qau_conv #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [31:0]           in_bits,
  output logic                  out_valid,
  output qau_pkg::out_word_t    out_word
);

  logic              v1_r, v2_r;
  logic              neg_r, zero_r, sat_r;
  logic [31:0]       mag_r, mag_nxt;
  logic              sat_nxt;
  logic [7:0]        ex;
  logic [23:0]       mant;
  logic signed [9:0] sh;
  logic [9:0]        rsh;
  qau_pkg::out_word_t word_r, word_nxt;

  assign ex   = in_bits[30:23];
  assign mant = {1'b1, in_bits[22:0]};
  assign sh   = $signed({2'b00, ex}) - 10'(qau_pkg::CONV_BIAS - FRAC_BITS);
  assign rsh  = -sh;

  always_comb begin
    sat_nxt = (ex == qau_pkg::EXP_MAX) || (sh > 10'(qau_pkg::SHIFT_MAX));
    if (sh >= 0) begin
      mag_nxt = {8'd0, mant} << sh[3:0];
    end else if (rsh >= 10'd32) begin
      mag_nxt = '0;
    end else begin
      mag_nxt = {8'd0, mant} >> rsh[4:0];
    end
  end

  always_comb begin
    word_nxt.status = qau_pkg::ST_OK;
    word_nxt.result = neg_r ? -mag_r : mag_r;
    if (zero_r) begin
      word_nxt.result = '0;
    end else if (sat_r || (neg_r ? (mag_r > qau_pkg::NEG_SAT) : (mag_r > qau_pkg::POS_SAT))) begin
      word_nxt.result = neg_r ? qau_pkg::NEG_SAT : qau_pkg::POS_SAT;
      word_nxt.status = qau_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    neg_r  <= in_bits[31];
    zero_r <= (ex == 8'd0);
    sat_r  <= sat_nxt;
    mag_r  <= mag_nxt;
    word_r <= word_nxt;
  end

  assign out_valid = v2_r;
  assign out_word  = word_r;

endmodule

>>> hdl/qau_div.sv
`timescale 1ns / 1ps

module qau_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [31:0]    in_a,
  input  logic signed [31:0]    in_b,
  output logic                  out_valid,
  output qau_pkg::out_word_t    out_word
);

  localparam int DW = 32 + FRAC_BITS;

  logic          v_r    [0:DW];
  logic          div0_r [0:DW];
  logic          aneg_r [0:DW];
  logic          neg_r  [0:DW];
  logic [31:0]   dvs_r  [0:DW];
  logic [31:0]   rem_r  [0:DW];
  logic [DW-1:0] num_r  [0:DW];

  logic               vo_r;
  qau_pkg::out_word_t word_r, word_nxt;
  logic [31:0]        abs_a, abs_b;

  assign abs_a = in_a[31] ? -in_a : in_a;
  assign abs_b = in_b[31] ? -in_b : in_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    div0_r[0] <= (in_b == 32'sd0);
    aneg_r[0] <= in_a[31];
    neg_r[0]  <= in_a[31] ^ in_b[31];
    dvs_r[0]  <= abs_b;
    rem_r[0]  <= '0;
    num_r[0]  <= {abs_a, FRAC_BITS'(0)};
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [32:0] trial, diff;
    logic        ge;

    assign trial = {rem_r[k], num_r[k][DW-1]};
    assign diff  = trial - {1'b0, dvs_r[k]};
    assign ge    = trial >= {1'b0, dvs_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      div0_r[k+1] <= div0_r[k];
      aneg_r[k+1] <= aneg_r[k];
      neg_r[k+1]  <= neg_r[k];
      dvs_r[k+1]  <= dvs_r[k];
      rem_r[k+1]  <= ge ? diff[31:0] : trial[31:0];
      num_r[k+1]  <= {num_r[k][DW-2:0], ge};
    end
  end

  always_comb begin
    word_nxt.result = neg_r[DW] ? -num_r[DW][31:0] : num_r[DW][31:0];
    word_nxt.status = qau_pkg::ST_OK;
    if (div0_r[DW]) begin
      word_nxt.result = aneg_r[DW] ? qau_pkg::NEG_SAT : qau_pkg::POS_SAT;
      word_nxt.status = qau_pkg::ST_DIV0;
    end else if (neg_r[DW] ? (num_r[DW] > DW'(qau_pkg::NEG_SAT))
                           : (num_r[DW] > DW'(qau_pkg::POS_SAT))) begin
      word_nxt.result = neg_r[DW] ? qau_pkg::NEG_SAT : qau_pkg::POS_SAT;
      word_nxt.status = qau_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[DW];
    end
    word_r <= word_nxt;
  end

  assign out_valid = vo_r;
  assign out_word  = word_r;

endmodule

>>> hdl/q16_16_arith_unit.sv
`timescale 1ns / 1ps
// channel   ports                          direction
// command   start, busy, in_word           in
// result    out_valid, out_word            out
//
// one word accepted per cycle while busy is low, every command in flight at once
// latency is the same for every command, set by the bit-per-stage divider
// synchronous reset clears all valid bits; busy is high for the cycle after reset
// results are strobed for one cycle and cannot be held off

module q16_16_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  qau_pkg::in_word_t     in_word,
  output logic                  out_valid,
  output qau_pkg::out_word_t    out_word
);

  localparam int DW = 32 + FRAC_BITS;

  logic busy_r, acc;
  logic mul_v, cnv_v, div_v;
  qau_pkg::out_word_t mul_w, cnv_w, div_w;
  logic oth_r [0:1];

  logic               late_v_r [0:DW-1];
  qau_pkg::out_word_t late_w_r [0:DW-1];
  qau_pkg::out_word_t merge_w;

  logic               out_v_r;
  qau_pkg::out_word_t out_w_r, out_w_nxt;

  assign acc = start && !busy_r;

  qau_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n,
    .in_valid (acc && (in_word.command == qau_pkg::CMD_MUL)),
    .in_a     (in_word.operand_a),
    .in_b     (in_word.operand_b),
    .out_valid(mul_v),
    .out_word (mul_w)
  );

  qau_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
    .clk, .rst_n,
    .in_valid (acc && (in_word.command == qau_pkg::CMD_CONV)),
    .in_bits  (in_word.operand_a),
    .out_valid(cnv_v),
    .out_word (cnv_w)
  );

  qau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n,
    .in_valid (acc && (in_word.command == qau_pkg::CMD_DIV)),
    .in_a     (in_word.operand_a),
    .in_b     (in_word.operand_b),
    .out_valid(div_v),
    .out_word (div_w)
  );

  always_comb begin
    merge_w.result = '0;
    merge_w.status = qau_pkg::ST_OK;
    if (mul_v) begin
      merge_w = mul_w;
    end else if (cnv_v) begin
      merge_w = cnv_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      oth_r[0] <= 1'b0;
      oth_r[1] <= 1'b0;
      late_v_r[0] <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      oth_r[0] <= acc && (in_word.command != qau_pkg::CMD_MUL)
                      && (in_word.command != qau_pkg::CMD_DIV)
                      && (in_word.command != qau_pkg::CMD_CONV);
      oth_r[1] <= oth_r[0];
      late_v_r[0] <= mul_v || cnv_v || oth_r[1];
    end
    late_w_r[0] <= merge_w;
  end

  for (genvar k = 1; k < DW; k++) begin : g_late
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        late_v_r[k] <= 1'b0;
      end else begin
        late_v_r[k] <= late_v_r[k-1];
      end
      late_w_r[k] <= late_w_r[k-1];
    end
  end

  assign out_w_nxt = div_v ? div_w : late_w_r[DW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= div_v || late_v_r[DW-1];
    end
    out_w_r <= out_w_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_v_r;
  assign out_word  = out_w_r;

`ifndef SYNTH
  a_one_short_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_v && cnv_v))
    else $error("multiply and convert results collide");

  a_div_vs_late: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_v && late_v_r[DW-1]))
    else $error("divider result collides with delayed result");

  a_div0_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == qau_pkg::ST_DIV0)) |->
      ((out_word.result == qau_pkg::POS_SAT) || (out_word.result == qau_pkg::NEG_SAT)))
    else $error("division by zero without saturated result");
`endif

endmodule
